### sv/sdxc_pkg.sv
// Shared types, character codes and hex digit decode for the sentence deframer.
`default_nettype none
package sdxc_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BODY = 2'd1,
        PH_DIG1 = 2'd2,
        PH_DIG2 = 2'd3
    } phase_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    localparam int unsigned LEN_W = 11;
    localparam int unsigned LEN_MAX = 2047;

    // Bit 4 flags a byte that is not an upper-case hex digit; low nibble is then zero.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        r = 5'b1_0000;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
            r = {1'b0, d[3:0]};
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = c - CH_UPPER_A + 8'd10;
            r = {1'b0, d[3:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/sentence_deframer_xor_check_top.sv
// An accepted byte's result item is in the output register in the cycle after it.
// One byte per cycle, stalled while a full output waits; it refills in the cycle taken.
// Each byte updates the frame state and forms its result in a single combinational pass.
// Reset (aresetn low, synchronous) returns to hunting for '$' and empties the output.
// Bytes outside a frame, '$', '*' and the first checksum digit give no result item.
`default_nettype none
module sentence_deframer_xor_check_top #(
    parameter int unsigned MAX_BODY = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [8] check_ok, [19:9] body_length
    output logic             m_tuser,   // [0] item_kind
    output logic             m_tlast    // frame_last
);
    import sdxc_pkg::*;

    localparam int unsigned LEN_CAP = (MAX_BODY > LEN_MAX) ? LEN_MAX : MAX_BODY;
    localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);

    phase_t           phase_reg, phase_next;
    logic [7:0]       xor_reg, xor_next;
    logic [3:0]       hi_reg, hi_next;
    logic             bad_reg, bad_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic             vld_reg, vld_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             kind_reg, kind_next;
    logic             ok_reg, ok_next;
    logic [LEN_W-1:0] olen_reg, olen_next;

    logic             accept;
    logic             emit;
    logic [4:0]       dig;

    assign s_tready = !vld_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign dig      = hex_decode(s_tdata);

    always_comb begin
        phase_next = phase_reg;
        xor_next   = xor_reg;
        hi_next    = hi_reg;
        bad_next   = bad_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        obyte_next = obyte_reg;
        kind_next  = kind_reg;
        ok_next    = ok_reg;
        olen_next  = olen_reg;
        if (accept) begin
            if (s_tdata == CH_DOLLAR) begin
                phase_next = PH_BODY;
                xor_next   = '0;
                hi_next    = '0;
                bad_next   = 1'b0;
                len_next   = '0;
            end else begin
                unique case (phase_reg)
                    PH_HUNT: begin
                    end
                    PH_BODY: begin
                        if (s_tdata == CH_STAR) begin
                            phase_next = PH_DIG1;
                        end else begin
                            xor_next = xor_reg ^ s_tdata;
                            if (len_reg >= LEN_CAP_V) begin
                                bad_next = 1'b1;
                            end else begin
                                len_next = len_reg + LEN_W'(1);
                            end
                            emit       = 1'b1;
                            obyte_next = s_tdata;
                            kind_next  = 1'b0;
                            ok_next    = 1'b0;
                            olen_next  = '0;
                        end
                    end
                    PH_DIG1: begin
                        hi_next    = dig[3:0];
                        bad_next   = bad_reg | dig[4];
                        phase_next = PH_DIG2;
                    end
                    PH_DIG2: begin
                        emit       = 1'b1;
                        obyte_next = '0;
                        kind_next  = 1'b1;
                        ok_next    = !bad_reg && !dig[4] && (xor_reg == {hi_reg, dig[3:0]});
                        olen_next  = len_reg;
                        bad_next   = bad_reg | dig[4];
                        phase_next = PH_HUNT;
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
        if (emit) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            xor_reg   <= '0;
            hi_reg    <= '0;
            bad_reg   <= 1'b0;
            len_reg   <= '0;
            vld_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            hi_reg    <= hi_next;
            bad_reg   <= bad_next;
            len_reg   <= len_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        obyte_reg <= obyte_next;
        kind_reg  <= kind_next;
        ok_reg    <= ok_next;
        olen_reg  <= olen_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {4'b0000, olen_reg, ok_reg, obyte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = kind_reg;

`ifndef NO_ASSERTIONS
    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_CAP_V)
        else $error("length count above cap");

    a_body_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg && !kind_reg) |-> (!ok_reg && olen_reg == '0))
        else $error("body item carries verdict fields");

    a_verdict_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg && kind_reg) |-> (obyte_reg == '0))
        else $error("verdict item carries a data byte");

    a_verdict_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_DIG2 && s_tdata != CH_DOLLAR) |=>
            (phase_reg == PH_HUNT && vld_reg && kind_reg))
        else $error("second digit did not close the frame");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !vld_reg)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
